/* rtl/fccs_pkg.sv */
package fccs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CONST_FRAC = 32;
	localparam int ALPHA_FRAC = 16;

	localparam int RAW_W = 16;
	localparam int ALPHA_W = 16;
	localparam int VAL_W = 48;
	localparam int TOT_W = 64;
	localparam int OPD_W = 64;
	localparam int PROD_W = 2 * OPD_W;
	localparam int SHIFT_W = 6;
	localparam int CH_W = 3;
	localparam int N_CH = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(N_CH - 1);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_REST = 1'b1;

	localparam logic [ALPHA_W-1:0] SMOOTH_FIRST_RST = 16'd459;
	localparam logic [ALPHA_W-1:0] SMOOTH_REST_RST = 16'd655;

	localparam logic [SHIFT_W-1:0] CAL_SHIFT = SHIFT_W'(CONST_FRAC - FRAC_BITS);
	localparam logic [SHIFT_W-1:0] PROD_SHIFT = SHIFT_W'(FRAC_BITS);
	localparam logic [SHIFT_W-1:0] SMO_SHIFT = SHIFT_W'(ALPHA_FRAC);
	localparam logic [SHIFT_W-1:0] K_SHIFT = SHIFT_W'(CONST_FRAC);

	// calibration gains and offsets and output scale constants, 32 fraction bits
	localparam logic signed [OPD_W-1:0] G_CH1 = 64'sd1120170420;
	localparam logic signed [OPD_W-1:0] O_CH1 = 64'sd415254618046;
	localparam logic signed [OPD_W-1:0] G_CH2 = 64'sd298500227;
	localparam logic signed [OPD_W-1:0] O_CH2 = 64'sd30365418783;
	localparam logic signed [OPD_W-1:0] G_CH3 = 64'sd22958552455;
	localparam logic signed [OPD_W-1:0] G_CH4 = 64'sd1431655765;
	localparam logic signed [OPD_W-1:0] G_CH5 = 64'sd126272038502;
	localparam logic signed [OPD_W-1:0] K_POWER = 64'sd11392755;
	localparam logic signed [OPD_W-1:0] K_HP = 64'sd5839530;
	localparam logic signed [OPD_W-1:0] K_FUEL = 64'sd185542587187;

	typedef enum logic [2:0] {
		T_IDLE,
		T_ISSUE,
		T_WAIT,
		T_ACC,
		T_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		OP_CAL,
		OP_SMO,
		OP_PROD,
		OP_PWR,
		OP_HP,
		OP_FUEL
	} op_t;

	typedef enum logic [2:0] {
		MU_IDLE,
		MU_MUL,
		MU_OFS,
		MU_MAG,
		MU_RND,
		MU_SAT,
		MU_DONE
	} mu_state_t;

	typedef struct packed {
		logic start;
		logic signed [OPD_W-1:0] a;
		logic signed [OPD_W-1:0] b;
		logic signed [OPD_W-1:0] bias;
		logic use_bias;
		logic [SHIFT_W-1:0] shift;
		logic wide;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [OPD_W-1:0] result;
	} mul_rsp_t;

	function automatic logic signed [OPD_W-1:0] cal_gain(input logic [CH_W-1:0] ch);
		logic signed [OPD_W-1:0] g;
		case (ch)
			3'd0: g = G_CH1;
			3'd1: g = G_CH2;
			3'd2: g = G_CH3;
			3'd3: g = G_CH4;
			default: g = G_CH5;
		endcase
		return g;
	endfunction

	// negated offset, added after the product
	function automatic logic signed [OPD_W-1:0] cal_bias(input logic [CH_W-1:0] ch);
		logic signed [OPD_W-1:0] o;
		case (ch)
			3'd0: o = -O_CH1;
			3'd1: o = -O_CH2;
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp48(input logic signed [VAL_W:0] x);
		logic signed [VAL_W-1:0] r;
		if (x[VAL_W] != x[VAL_W-1])
			r = x[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			r = x[VAL_W-1:0];
		return r;
	endfunction

	function automatic logic signed [TOT_W-1:0] sat_add64(input logic signed [TOT_W-1:0] a,
			input logic signed [TOT_W-1:0] b);
		logic signed [TOT_W:0] s;
		logic signed [TOT_W-1:0] r;
		s = {a[TOT_W-1], a} + {b[TOT_W-1], b};
		if (s[TOT_W] != s[TOT_W-1])
			r = s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
		else
			r = s[TOT_W-1:0];
		return r;
	endfunction

endpackage

/* rtl/fccs_if.sv */
interface fccs_sample_if;
	logic valid;
	logic ready;
	logic command;
	logic signed [fccs_pkg::RAW_W-1:0] raw_ch1;
	logic signed [fccs_pkg::RAW_W-1:0] raw_ch2;
	logic signed [fccs_pkg::RAW_W-1:0] raw_ch3;
	logic signed [fccs_pkg::RAW_W-1:0] raw_ch4;
	logic signed [fccs_pkg::RAW_W-1:0] raw_ch5;

	modport source(output valid, command, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
		input ready);
	modport sink(input valid, command, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
		output ready);
endinterface

interface fccs_result_if;
	logic valid;
	logic ready;
	logic signed [fccs_pkg::VAL_W-1:0] filt_ch1;
	logic signed [fccs_pkg::VAL_W-1:0] filt_ch2;
	logic signed [fccs_pkg::VAL_W-1:0] filt_ch3;
	logic signed [fccs_pkg::VAL_W-1:0] filt_ch4;
	logic signed [fccs_pkg::VAL_W-1:0] filt_ch5;
	logic signed [fccs_pkg::VAL_W-1:0] power_value;
	logic signed [fccs_pkg::VAL_W-1:0] horsepower_value;
	logic signed [fccs_pkg::VAL_W-1:0] fuel_rate;
	logic signed [fccs_pkg::TOT_W-1:0] ch4_total;

	modport source(output valid, filt_ch1, filt_ch2, filt_ch3, filt_ch4, filt_ch5,
		power_value, horsepower_value, fuel_rate, ch4_total, input ready);
	modport sink(input valid, filt_ch1, filt_ch2, filt_ch3, filt_ch4, filt_ch5,
		power_value, horsepower_value, fuel_rate, ch4_total, output ready);
endinterface

interface fccs_cfg_if;
	logic valid;
	logic ready;
	logic [fccs_pkg::CFG_IDX_W-1:0] index;
	logic [fccs_pkg::ALPHA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/fccs_mul_unit.sv */
module fccs_mul_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  fccs_pkg::mul_req_t  req,
	output fccs_pkg::mul_rsp_t  rsp
);

	fccs_pkg::mu_state_t state_q, state_d;

	logic [fccs_pkg::OPD_W-1:0] ma_q, mb_q;
	logic neg_q;
	logic [1:0] pp_q;
	logic [fccs_pkg::PROD_W-1:0] acc_q;
	logic signed [fccs_pkg::OPD_W-1:0] bias_q;
	logic use_bias_q;
	logic [fccs_pkg::SHIFT_W-1:0] shift_q;
	logic wide_q;
	logic signed [fccs_pkg::OPD_W-1:0] res_q;

	logic [31:0] a_half, b_half;
	logic [63:0] prod;
	logic [1:0] pos;
	logic [fccs_pkg::PROD_W-1:0] pp_ext;
	logic [fccs_pkg::PROD_W-1:0] ofs_sum;
	logic [fccs_pkg::PROD_W-1:0] mag_val;
	logic [fccs_pkg::PROD_W-1:0] rnd_sum;
	logic [fccs_pkg::OPD_W-1:0] lim;
	logic over;
	logic [fccs_pkg::OPD_W-1:0] sat_mag;

	// one 32x32 partial product per cycle over the operand magnitudes
	assign a_half = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign b_half = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
	assign prod = a_half * b_half;
	assign pos = {1'b0, pp_q[0]} + {1'b0, pp_q[1]};
	assign pp_ext = {64'd0, prod} << {pos, 5'd0};

	// signed product plus bias
	assign ofs_sum = (neg_q ? ~acc_q : acc_q) + {{(fccs_pkg::PROD_W-1){1'b0}}, neg_q}
		+ {{(fccs_pkg::PROD_W-fccs_pkg::OPD_W){bias_q[fccs_pkg::OPD_W-1]}}, bias_q};
	assign mag_val = acc_q[fccs_pkg::PROD_W-1] ? (~acc_q + 128'd1) : acc_q;

	// round half away from zero on the magnitude
	assign rnd_sum = (acc_q + (128'd1 << (shift_q - 6'd1))) >> shift_q;

	assign lim = wide_q ? (64'h7FFF_FFFF_FFFF_FFFF + {63'd0, neg_q})
		: (64'h0000_7FFF_FFFF_FFFF + {63'd0, neg_q});
	assign over = (|acc_q[fccs_pkg::PROD_W-1:fccs_pkg::OPD_W]) || (acc_q[63:0] > lim);
	assign sat_mag = over ? lim : acc_q[63:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			fccs_pkg::MU_IDLE: begin
				if (req.start)
					state_d = fccs_pkg::MU_MUL;
			end
			fccs_pkg::MU_MUL: begin
				if (pp_q == 2'd3)
					state_d = use_bias_q ? fccs_pkg::MU_OFS : fccs_pkg::MU_RND;
			end
			fccs_pkg::MU_OFS: state_d = fccs_pkg::MU_MAG;
			fccs_pkg::MU_MAG: state_d = fccs_pkg::MU_RND;
			fccs_pkg::MU_RND: state_d = fccs_pkg::MU_SAT;
			fccs_pkg::MU_SAT: state_d = fccs_pkg::MU_DONE;
			fccs_pkg::MU_DONE: state_d = fccs_pkg::MU_IDLE;
			default: state_d = fccs_pkg::MU_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != fccs_pkg::MU_IDLE);
		rsp.done = (state_q == fccs_pkg::MU_DONE);
		rsp.result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fccs_pkg::MU_IDLE;
			pp_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fccs_pkg::MU_MUL)
				pp_q <= pp_q + 2'd1;
			else
				pp_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fccs_pkg::MU_IDLE: begin
				if (req.start) begin
					ma_q <= req.a[63] ? (~req.a + 64'd1) : req.a;
					mb_q <= req.b[63] ? (~req.b + 64'd1) : req.b;
					neg_q <= req.a[63] ^ req.b[63];
					acc_q <= '0;
					bias_q <= req.bias;
					use_bias_q <= req.use_bias;
					shift_q <= req.shift;
					wide_q <= req.wide;
				end
			end
			fccs_pkg::MU_MUL: acc_q <= acc_q + pp_ext;
			fccs_pkg::MU_OFS: acc_q <= ofs_sum;
			fccs_pkg::MU_MAG: begin
				neg_q <= acc_q[fccs_pkg::PROD_W-1];
				acc_q <= mag_val;
			end
			fccs_pkg::MU_RND: acc_q <= rnd_sum;
			fccs_pkg::MU_SAT: res_q <= neg_q ? (~sat_mag + 64'd1) : sat_mag;
			default: ;
		endcase
	end

	a_shift_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fccs_pkg::MU_RND |-> shift_q != '0)
		else $error("rounding with zero shift");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> state_q == fccs_pkg::MU_IDLE)
		else $error("unit did not return to idle after done");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.start && state_q == fccs_pkg::MU_IDLE |=> state_q == fccs_pkg::MU_MUL && pp_q == 2'd0)
		else $error("request not started");

endmodule

/* rtl/five_channel_calibrate_smooth.sv */
// five-channel calibrate and smooth
// sample channel: a request with command low carries five raw signed counts; each is
// calibrated, run through its exponential smoother, and the block then forms power,
// horsepower, fuel rate and the running sum of filtered channel four. a request with
// command high clears all filters and the sum and returns a result of all zeros.
// result channel: one result per request, held in an output register until taken.
// cfg channel: writes smooth_first (index 0) or smooth_rest (index 1); always ready,
// to be written only while no request is in flight.
// completion: a clear posts its all-zero result directly, a sample after its last scaling step;
// the block is ready again in the same cycle that the result is posted.
// all multiplications run through one shared multiply/round/saturate unit built on a
// single 32x32 multiplier; calibration steps also add an offset there, 14 scaling steps
// per sample. a new request is taken once the previous one is finished.
// if the receiver stalls, the finished result waits in the output register and the
// next request is accepted and processed; its result waits until the register frees.
// reset: smoothing factors return to 459 and 655, filters and sum clear to zero,
// no result is pending.
module five_channel_calibrate_smooth (
	input  logic                  clk,
	input  logic                  arst_n,
	fccs_sample_if.sink           sample,
	fccs_result_if.source         result,
	fccs_cfg_if.sink              cfg
);

	fccs_pkg::top_state_t state_q, state_d;
	fccs_pkg::op_t op_q;
	logic [fccs_pkg::CH_W-1:0] ch_q;

	logic [fccs_pkg::ALPHA_W-1:0] smooth_first_q, smooth_rest_q;
	logic signed [fccs_pkg::VAL_W-1:0] filt_q [fccs_pkg::N_CH];
	logic signed [fccs_pkg::TOT_W-1:0] total_q;

	logic signed [fccs_pkg::RAW_W-1:0] raw_q [fccs_pkg::N_CH];
	logic signed [fccs_pkg::VAL_W-1:0] d_q;
	logic signed [fccs_pkg::OPD_W-1:0] prod_q;
	logic signed [fccs_pkg::VAL_W-1:0] pw_q, hp_q, fuel_q;

	logic out_valid_q;
	logic signed [fccs_pkg::VAL_W-1:0] out_filt_q [fccs_pkg::N_CH];
	logic signed [fccs_pkg::VAL_W-1:0] out_pw_q, out_hp_q, out_fuel_q;
	logic signed [fccs_pkg::TOT_W-1:0] out_total_q;

	fccs_pkg::mul_req_t mreq;
	fccs_pkg::mul_rsp_t mrsp;

	logic accept;
	logic out_free;
	logic signed [fccs_pkg::VAL_W-1:0] mres48;
	logic signed [fccs_pkg::VAL_W-1:0] y_cur;
	logic [fccs_pkg::ALPHA_W-1:0] alpha;

	assign accept = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;
	assign mres48 = mrsp.result[fccs_pkg::VAL_W-1:0];
	assign y_cur = filt_q[ch_q];
	assign alpha = (ch_q == '0) ? smooth_first_q : smooth_rest_q;

	fccs_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fccs_pkg::T_IDLE: begin
				if (sample.valid)
					state_d = (sample.command == fccs_pkg::CMD_CLEAR) ? fccs_pkg::T_OUT
						: fccs_pkg::T_ISSUE;
			end
			fccs_pkg::T_ISSUE: state_d = fccs_pkg::T_WAIT;
			fccs_pkg::T_WAIT: begin
				if (mrsp.done) begin
					case (op_q)
						fccs_pkg::OP_SMO:
							state_d = (ch_q == fccs_pkg::LAST_CH) ? fccs_pkg::T_ACC
								: fccs_pkg::T_ISSUE;
						fccs_pkg::OP_FUEL: state_d = fccs_pkg::T_OUT;
						default: state_d = fccs_pkg::T_ISSUE;
					endcase
				end
			end
			fccs_pkg::T_ACC: state_d = fccs_pkg::T_ISSUE;
			fccs_pkg::T_OUT: begin
				if (out_free)
					state_d = fccs_pkg::T_IDLE;
			end
			default: state_d = fccs_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == fccs_pkg::T_IDLE);
		cfg.ready = 1'b1;

		result.valid = out_valid_q;
		result.filt_ch1 = out_filt_q[0];
		result.filt_ch2 = out_filt_q[1];
		result.filt_ch3 = out_filt_q[2];
		result.filt_ch4 = out_filt_q[3];
		result.filt_ch5 = out_filt_q[4];
		result.power_value = out_pw_q;
		result.horsepower_value = out_hp_q;
		result.fuel_rate = out_fuel_q;
		result.ch4_total = out_total_q;

		mreq.start = (state_q == fccs_pkg::T_ISSUE);
		mreq.bias = '0;
		mreq.use_bias = 1'b0;
		mreq.wide = 1'b0;
		case (op_q)
			fccs_pkg::OP_CAL: begin
				mreq.a = {{(fccs_pkg::OPD_W-fccs_pkg::RAW_W){raw_q[ch_q][fccs_pkg::RAW_W-1]}},
					raw_q[ch_q]};
				mreq.b = fccs_pkg::cal_gain(ch_q);
				mreq.bias = fccs_pkg::cal_bias(ch_q);
				mreq.use_bias = 1'b1;
				mreq.shift = fccs_pkg::CAL_SHIFT;
			end
			fccs_pkg::OP_SMO: begin
				mreq.a = {{(fccs_pkg::OPD_W-fccs_pkg::VAL_W){d_q[fccs_pkg::VAL_W-1]}}, d_q};
				mreq.b = {{(fccs_pkg::OPD_W-fccs_pkg::ALPHA_W){1'b0}}, alpha};
				mreq.shift = fccs_pkg::SMO_SHIFT;
			end
			fccs_pkg::OP_PROD: begin
				mreq.a = {{(fccs_pkg::OPD_W-fccs_pkg::VAL_W){filt_q[0][fccs_pkg::VAL_W-1]}},
					filt_q[0]};
				mreq.b = {{(fccs_pkg::OPD_W-fccs_pkg::VAL_W){filt_q[2][fccs_pkg::VAL_W-1]}},
					filt_q[2]};
				mreq.shift = fccs_pkg::PROD_SHIFT;
				mreq.wide = 1'b1;
			end
			fccs_pkg::OP_PWR: begin
				mreq.a = prod_q;
				mreq.b = fccs_pkg::K_POWER;
				mreq.shift = fccs_pkg::K_SHIFT;
			end
			fccs_pkg::OP_HP: begin
				mreq.a = {{(fccs_pkg::OPD_W-fccs_pkg::VAL_W){pw_q[fccs_pkg::VAL_W-1]}}, pw_q};
				mreq.b = fccs_pkg::K_HP;
				mreq.shift = fccs_pkg::K_SHIFT;
			end
			fccs_pkg::OP_FUEL: begin
				mreq.a = {{(fccs_pkg::OPD_W-fccs_pkg::VAL_W){hp_q[fccs_pkg::VAL_W-1]}}, hp_q};
				mreq.b = fccs_pkg::K_FUEL;
				mreq.shift = fccs_pkg::K_SHIFT;
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
				mreq.shift = fccs_pkg::K_SHIFT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fccs_pkg::T_IDLE;
			op_q <= fccs_pkg::OP_CAL;
			ch_q <= '0;
			smooth_first_q <= fccs_pkg::SMOOTH_FIRST_RST;
			smooth_rest_q <= fccs_pkg::SMOOTH_REST_RST;
			for (int i = 0; i < fccs_pkg::N_CH; i++)
				filt_q[i] <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					fccs_pkg::REG_SMOOTH_FIRST: smooth_first_q <= cfg.data;
					fccs_pkg::REG_SMOOTH_REST: smooth_rest_q <= cfg.data;
					default: ;
				endcase
			end

			if (accept) begin
				ch_q <= '0;
				op_q <= fccs_pkg::OP_CAL;
				if (sample.command == fccs_pkg::CMD_CLEAR) begin
					for (int i = 0; i < fccs_pkg::N_CH; i++)
						filt_q[i] <= '0;
					total_q <= '0;
				end
			end

			if (state_q == fccs_pkg::T_WAIT && mrsp.done) begin
				case (op_q)
					fccs_pkg::OP_CAL: op_q <= fccs_pkg::OP_SMO;
					fccs_pkg::OP_SMO: begin
						filt_q[ch_q] <= fccs_pkg::clamp48({y_cur[fccs_pkg::VAL_W-1], y_cur}
							+ {mres48[fccs_pkg::VAL_W-1], mres48});
						if (ch_q == fccs_pkg::LAST_CH) begin
							op_q <= fccs_pkg::OP_PROD;
						end else begin
							ch_q <= ch_q + 3'd1;
							op_q <= fccs_pkg::OP_CAL;
						end
					end
					fccs_pkg::OP_PROD: op_q <= fccs_pkg::OP_PWR;
					fccs_pkg::OP_PWR: op_q <= fccs_pkg::OP_HP;
					fccs_pkg::OP_HP: op_q <= fccs_pkg::OP_FUEL;
					default: ;
				endcase
			end

			// channel four has its new value by now
			if (state_q == fccs_pkg::T_ACC)
				total_q <= fccs_pkg::sat_add64(total_q,
					{{(fccs_pkg::TOT_W-fccs_pkg::VAL_W){filt_q[3][fccs_pkg::VAL_W-1]}},
					filt_q[3]});

			if (state_q == fccs_pkg::T_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q[0] <= sample.raw_ch1;
			raw_q[1] <= sample.raw_ch2;
			raw_q[2] <= sample.raw_ch3;
			raw_q[3] <= sample.raw_ch4;
			raw_q[4] <= sample.raw_ch5;
			if (sample.command == fccs_pkg::CMD_CLEAR) begin
				pw_q <= '0;
				hp_q <= '0;
				fuel_q <= '0;
			end
		end

		if (state_q == fccs_pkg::T_WAIT && mrsp.done) begin
			case (op_q)
				fccs_pkg::OP_CAL:
					d_q <= fccs_pkg::clamp48({mres48[fccs_pkg::VAL_W-1], mres48}
						- {y_cur[fccs_pkg::VAL_W-1], y_cur});
				fccs_pkg::OP_PROD: prod_q <= mrsp.result;
				fccs_pkg::OP_PWR: pw_q <= mres48;
				fccs_pkg::OP_HP: hp_q <= mres48;
				fccs_pkg::OP_FUEL: fuel_q <= mres48;
				default: ;
			endcase
		end

		if (state_q == fccs_pkg::T_OUT && out_free) begin
			for (int i = 0; i < fccs_pkg::N_CH; i++)
				out_filt_q[i] <= filt_q[i];
			out_pw_q <= pw_q;
			out_hp_q <= hp_q;
			out_fuel_q <= fuel_q;
			out_total_q <= total_q;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != fccs_pkg::T_IDLE)
		else $error("accepted request did not start");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mrsp.busy)
		else $error("multiply issued while unit busy");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= fccs_pkg::LAST_CH)
		else $error("channel index out of range");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fccs_pkg::T_OUT && out_free |=> out_valid_q && state_q == fccs_pkg::T_IDLE)
		else $error("result not posted");

endmodule
